// ----- rtl/iirbp_pkg.sv -----
// shared types, constants and coefficient arithmetic for the order-8 band-pass filter
`timescale 1ns / 1ps
`default_nettype none

package iirbp_pkg;

	// sample format and filter shape
	localparam int SAMPLE_W       = 24;
	localparam int FILTER_ORDER   = 8;
	localparam int COEF_FRAC_BITS = 40;

	// multiplier digit width, bits of the operand consumed per cycle while stepping
	localparam int DIGIT_W = 8;

	// non-zero taps: five feed-forward, then eight feedback
	localparam int NUM_FWD  = 5;
	localparam int NUM_TAPS = NUM_FWD + FILTER_ORDER;
	localparam int TAP_W    = $clog2(NUM_TAPS + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_in_block;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       block_done;
	} result_t;

	// digit-serial multiplier control
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} mul_ctl_t;

	// history update control
	typedef struct packed {
		logic push;
		logic clear;
	} hist_ctl_t;

	// rounding stage control
	typedef struct packed {
		logic rnd;
		logic clamp;
	} rnd_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_RND,
		ST_CLAMP,
		ST_OUT
	} state_t;

	// decimal coefficient of one tap, rounded to nearest at frac fractional bits;
	// feedback terms carry the sign they have in the accumulated sum
	function automatic logic signed [63:0] tap_coef(input int tap, input int frac);
		logic [63:0] digits;
		int          places;
		logic        neg;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] r;
		int          i;
		int          k;
		digits = '0;
		places = 0;
		neg    = 1'b0;
		case (tap)
			0:  begin digits = 64'd183216023369609;   places = 18; neg = 1'b0; end
			1:  begin digits = 64'd732864093478438;   places = 18; neg = 1'b1; end
			2:  begin digits = 64'd1099296140217657;  places = 18; neg = 1'b0; end
			3:  begin digits = 64'd732864093478438;   places = 18; neg = 1'b1; end
			4:  begin digits = 64'd183216023369609;   places = 18; neg = 1'b0; end
			5:  begin digits = 64'd7224163591308814;  places = 15; neg = 1'b0; end
			6:  begin digits = 64'd22958620298726956; places = 15; neg = 1'b1; end
			7:  begin digits = 64'd41926271928661706; places = 15; neg = 1'b0; end
			8:  begin digits = 64'd4812271256334232;  places = 14; neg = 1'b1; end
			9:  begin digits = 64'd3555142228952962;  places = 14; neg = 1'b0; end
			10: begin digits = 64'd16509171846911332; places = 15; neg = 1'b1; end
			11: begin digits = 64'd4406124281448874;  places = 15; neg = 1'b0; end
			12: begin digits = 64'd5174781997880404;  places = 16; neg = 1'b1; end
			default: begin digits = '0; places = 0; neg = 1'b0; end
		endcase
		p = 64'd1;
		for (k = 0; k < places; k++) begin
			p = p * 64'd10;
		end
		// integer part by restoring long division
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[62:0], digits[i]};
			q = {q[62:0], 1'b0};
			if (r >= p) begin
				r    = r - p;
				q[0] = 1'b1;
			end
		end
		// fraction bits plus one guard bit for rounding
		for (k = 0; k <= frac; k++) begin
			r = {r[62:0], 1'b0};
			q = {q[62:0], 1'b0};
			if (r >= p) begin
				r    = r - p;
				q[0] = 1'b1;
			end
		end
		q = (q + 64'd1) >> 1;
		return neg ? -signed'(q) : signed'(q);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/iirbp_dsmul.sv -----
// digit-serial signed multiplier, operand shifted out one digit per cycle of step, lsb first
`timescale 1ns / 1ps
`default_nettype none

module iirbp_dsmul #(
	parameter int COEF_W  = iirbp_pkg::COEF_FRAC_BITS + 8,
	parameter int NUM_DIG = (COEF_W + iirbp_pkg::DIGIT_W - 1) / iirbp_pkg::DIGIT_W
) (
	input  wire                             clk,
	input  wire iirbp_pkg::mul_ctl_t        ctl,
	input  wire logic signed [COEF_W-1:0]   coef,
	input  wire logic signed [COEF_W-1:0]   operand,
	output logic signed [COEF_W + iirbp_pkg::DIGIT_W + 2 + NUM_DIG * iirbp_pkg::DIGIT_W - 1:0]
		product
);

	localparam int DW  = iirbp_pkg::DIGIT_W;
	localparam int SHW = NUM_DIG * DW;
	localparam int HW  = COEF_W + DW + 2;

	logic signed [COEF_W-1:0] coef_q;
	logic        [SHW-1:0]    sh_q;
	logic signed [HW-1:0]     hi_q;
	logic signed [DW:0]       dig;
	logic signed [COEF_W+DW:0] term;
	logic signed [HW-1:0]     sum;

	// current digit, the top one carries the sign
	assign dig  = signed'({ctl.last & sh_q[DW-1], sh_q[DW-1:0]});
	assign term = coef_q * dig;
	assign sum  = hi_q + HW'(term);

	// partial product high part and the shift line that trades operand for product digits
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			coef_q <= coef;
			sh_q   <= SHW'(operand);
			hi_q   <= '0;
		end else if (ctl.step) begin
			sh_q <= {sum[DW-1:0], sh_q[SHW-1:DW]};
			hi_q <= sum >>> DW;
		end
	end

	assign product = signed'({hi_q, sh_q});

endmodule

`default_nettype wire

// ----- rtl/iirbp_hist.sv -----
// input and output sample history with tap operand selection
`timescale 1ns / 1ps
`default_nettype none

module iirbp_hist #(
	parameter int COEF_W = iirbp_pkg::COEF_FRAC_BITS + 8
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire iirbp_pkg::hist_ctl_t                    ctl,
	input  wire logic [iirbp_pkg::TAP_W-1:0]             tap,
	input  wire logic signed [iirbp_pkg::SAMPLE_W-1:0]   x_cur,
	input  wire logic signed [iirbp_pkg::SAMPLE_W-1:0]   x_new,
	input  wire logic signed [COEF_W-1:0]                y_new,
	output logic signed [COEF_W-1:0]                     operand
);

	localparam int SW    = iirbp_pkg::SAMPLE_W;
	localparam int ORD   = iirbp_pkg::FILTER_ORDER;
	localparam int IDX_W = $clog2(ORD);
	localparam int PAD_W = COEF_W - SW;
	localparam int TW    = iirbp_pkg::TAP_W;

	logic signed [SW-1:0]     x_hist_q [ORD];
	logic signed [COEF_W-1:0] y_hist_q [ORD];
	logic signed [SW-1:0]     x_sel;
	logic [TW-1:0]            x_idx;
	logic [TW-1:0]            y_idx;

	// history shift lines, cleared at reset and after the last beat of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORD; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
		end else if (ctl.push) begin
			if (ctl.clear) begin
				for (int i = 0; i < ORD; i++) begin
					x_hist_q[i] <= '0;
					y_hist_q[i] <= '0;
				end
			end else begin
				x_hist_q[0] <= x_new;
				y_hist_q[0] <= y_new;
				for (int i = 1; i < ORD; i++) begin
					x_hist_q[i] <= x_hist_q[i-1];
					y_hist_q[i] <= y_hist_q[i-1];
				end
			end
		end
	end

	// feed-forward taps use the even delays x[n-2k], feedback taps y[n-1-k]
	assign x_idx = TW'({tap, 1'b0}) - TW'(1);
	assign y_idx = tap - TW'(iirbp_pkg::NUM_FWD);

	always_comb begin
		if (tap == '0) begin
			x_sel = x_cur;
		end else begin
			x_sel = x_hist_q[x_idx[IDX_W-1:0]];
		end
		if (tap < TW'(iirbp_pkg::NUM_FWD)) begin
			// sample in Q8.16 aligned to the coefficient format
			operand = signed'({x_sel, {PAD_W{1'b0}}});
		end else begin
			operand = y_hist_q[y_idx[IDX_W-1:0]];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iirbp_round.sv -----
// rounding and saturation of the accumulated sum to the feedback and output formats
`timescale 1ns / 1ps
`default_nettype none

module iirbp_round #(
	parameter int FRAC  = iirbp_pkg::COEF_FRAC_BITS,
	parameter int ACC_W = 2 * FRAC + 20
) (
	input  wire                                         clk,
	input  wire iirbp_pkg::rnd_ctl_t                    ctl,
	input  wire logic signed [ACC_W-1:0]                acc,
	output logic signed [FRAC+7:0]                      yq,
	output logic signed [iirbp_pkg::SAMPLE_W-1:0]       filtered
);

	localparam int CW  = FRAC + 8;
	localparam int SHW = ACC_W - FRAC;
	localparam int SW  = iirbp_pkg::SAMPLE_W;
	localparam int DROP = FRAC - 16;

	localparam logic signed [ACC_W-1:0] HALF =
		signed'({{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
	localparam logic signed [CW:0] OUT_HALF =
		signed'({{(CW-DROP+1){1'b0}}, 1'b1, {(DROP-1){1'b0}}});

	logic signed [ACC_W-1:0] sum_s1;
	logic signed [SHW-1:0]   shifted;
	logic                    y_ovf;
	logic signed [CW-1:0]    y_sat;
	logic signed [CW-1:0]    yq_q;
	logic signed [CW:0]      t;
	logic signed [SW:0]      o;

	// round half up, then drop the fraction bits of the product scale
	assign shifted = sum_s1[ACC_W-1:FRAC];
	assign y_ovf   = shifted[SHW-1:CW-1] != {(SHW-CW+1){shifted[SHW-1]}};

	always_comb begin
		if (y_ovf) begin
			y_sat = shifted[SHW-1] ? signed'({1'b1, {(CW-1){1'b0}}})
			                       : signed'({1'b0, {(CW-1){1'b1}}});
		end else begin
			y_sat = shifted[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rnd) begin
			sum_s1 <= acc + HALF;
		end
		if (ctl.clamp) begin
			yq_q <= y_sat;
		end
	end

	assign yq = yq_q;

	// second rounding down to Q8.16 with saturation to the sample range
	assign t = signed'({yq_q[CW-1], yq_q}) + OUT_HALF;
	assign o = t[CW:DROP];

	always_comb begin
		if (o[SW] != o[SW-1]) begin
			filtered = o[SW] ? signed'({1'b1, {(SW-1){1'b0}}})
			                 : signed'({1'b0, {(SW-1){1'b1}}});
		end else begin
			filtered = o[SW-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iir_bandpass_filter_order8_core.sv -----
// top level: control sequencer, coefficient table, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none

// Eighth-order direct-form-I band-pass filter with fixed coefficients. Each beat on
// the item channel carries one signed Q8.16 sample and yields exactly one filtered
// Q8.16 sample on the result channel, with block_done echoing last_in_block; after a
// beat marked last_in_block the history is cleared. The five non-zero feed-forward
// taps and eight feedback taps run one after another through a single digit-serial
// multiplier taking 8 operand bits a cycle. Each tap loads the multiplier, steps
// it through every operand digit and adds the product to the sum; the sum is then
// rounded, clamped and written to the output register.
// The result sits in an output register, so a new item is taken while an earlier
// result is still stalled; the block stalls its input while the filter sum for an
// item is in progress and while a finished sum waits for that register to free.
module iir_bandpass_filter_order8_core #(
	parameter int COEF_FRAC_BITS = iirbp_pkg::COEF_FRAC_BITS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  wire iirbp_pkg::item_t item,
	output logic                result_valid,
	input  wire                 result_stall,
	output iirbp_pkg::result_t  result
);

	localparam int CW      = COEF_FRAC_BITS + 8;
	localparam int DW      = iirbp_pkg::DIGIT_W;
	localparam int NUM_DIG = (CW + DW - 1) / DW;
	localparam int PW      = CW + DW + 2 + NUM_DIG * DW;
	localparam int ACC_W   = 2 * COEF_FRAC_BITS + 20;
	localparam int DGW     = $clog2(NUM_DIG);
	localparam int TW      = iirbp_pkg::TAP_W;
	localparam int NT      = iirbp_pkg::NUM_TAPS;
	localparam int SW      = iirbp_pkg::SAMPLE_W;

	localparam logic [DGW-1:0] DIG_LAST = DGW'(NUM_DIG - 1);
	localparam logic [TW-1:0]  TAP_LAST = TW'(NT - 1);

	localparam logic signed [CW-1:0] COEF [NT] = '{
		CW'(iirbp_pkg::tap_coef(0,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(1,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(2,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(3,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(4,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(5,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(6,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(7,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(8,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(9,  COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(10, COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(11, COEF_FRAC_BITS)),
		CW'(iirbp_pkg::tap_coef(12, COEF_FRAC_BITS))
	};

	iirbp_pkg::state_t    state_q;
	iirbp_pkg::state_t    state_nxt;
	iirbp_pkg::mul_ctl_t  mul_ctl;
	iirbp_pkg::hist_ctl_t hist_ctl;
	iirbp_pkg::rnd_ctl_t  rnd_ctl;

	logic [TW-1:0]           tap_q;
	logic [TW-1:0]           tap_sel;
	logic [DGW-1:0]          dig_q;
	logic signed [CW-1:0]    coef_sel;
	logic signed [CW-1:0]    operand;
	logic signed [PW-1:0]    product;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [CW-1:0]    yq;
	logic signed [SW-1:0]    filtered;
	logic signed [SW-1:0]    x_q;
	logic                    last_q;
	logic                    in_fire;
	logic                    out_load;
	logic                    res_valid_q;
	iirbp_pkg::result_t      res_q;

	assign item_stall   = state_q != iirbp_pkg::ST_IDLE;
	assign in_fire      = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// tap whose coefficient and operand are loaded this cycle
	assign tap_sel  = (state_q == iirbp_pkg::ST_ACC) ? tap_q + TW'(1) : '0;
	assign coef_sel = (tap_sel < TW'(NT)) ? COEF[tap_sel] : '0;

	// next state and unit controls
	always_comb begin
		state_nxt      = state_q;
		mul_ctl        = '0;
		hist_ctl       = '0;
		rnd_ctl        = '0;
		out_load       = 1'b0;
		mul_ctl.last   = dig_q == DIG_LAST;
		case (state_q)
			iirbp_pkg::ST_IDLE: begin
				if (item_valid) begin
					mul_ctl.load = 1'b1;
					state_nxt    = iirbp_pkg::ST_MUL;
				end
			end
			iirbp_pkg::ST_MUL: begin
				mul_ctl.step = 1'b1;
				if (dig_q == DIG_LAST) begin
					state_nxt = iirbp_pkg::ST_ACC;
				end
			end
			iirbp_pkg::ST_ACC: begin
				if (tap_q == TAP_LAST) begin
					state_nxt = iirbp_pkg::ST_RND;
				end else begin
					mul_ctl.load = 1'b1;
					state_nxt    = iirbp_pkg::ST_MUL;
				end
			end
			iirbp_pkg::ST_RND: begin
				rnd_ctl.rnd = 1'b1;
				state_nxt   = iirbp_pkg::ST_CLAMP;
			end
			iirbp_pkg::ST_CLAMP: begin
				rnd_ctl.clamp = 1'b1;
				state_nxt     = iirbp_pkg::ST_OUT;
			end
			iirbp_pkg::ST_OUT: begin
				if (!res_valid_q || !result_stall) begin
					out_load       = 1'b1;
					hist_ctl.push  = 1'b1;
					hist_ctl.clear = last_q;
					state_nxt      = iirbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = iirbp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// tap and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			dig_q <= '0;
		end else begin
			if (in_fire) begin
				tap_q <= '0;
			end else if (mul_ctl.load) begin
				tap_q <= tap_sel;
			end
			if (mul_ctl.load) begin
				dig_q <= '0;
			end else if (mul_ctl.step) begin
				dig_q <= dig_q + DGW'(1);
			end
		end
	end

	// item capture and sum of products
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= item.sample;
			last_q <= item.last_in_block;
			acc_q  <= '0;
		end else if (state_q == iirbp_pkg::ST_ACC) begin
			acc_q <= acc_q + product[ACC_W-1:0];
		end
	end

	// result register, its valid cleared when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.filtered   <= filtered;
			res_q.block_done <= last_q;
		end
	end

	iirbp_hist #(
		.COEF_W (CW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hist_ctl),
		.tap     (tap_sel),
		.x_cur   (item.sample),
		.x_new   (x_q),
		.y_new   (yq),
		.operand (operand)
	);

	iirbp_dsmul #(
		.COEF_W  (CW),
		.NUM_DIG (NUM_DIG)
	) u_dsmul (
		.clk     (clk),
		.ctl     (mul_ctl),
		.coef    (coef_sel),
		.operand (operand),
		.product (product)
	);

	iirbp_round #(
		.FRAC  (COEF_FRAC_BITS),
		.ACC_W (ACC_W)
	) u_round (
		.clk      (clk),
		.ctl      (rnd_ctl),
		.acc      (acc_q),
		.yq       (yq),
		.filtered (filtered)
	);

endmodule

`default_nettype wire
